>>> rtl/core/pce_pkg.sv
`default_nettype none

package pce_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 16;
   localparam int SEG_LIMIT = 16;

   localparam int DATA_W = 32;
   localparam int ENTRY_W = 4;
   localparam int SEG_CNT_W = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SEGMENTS_IN_USE = 1'b0;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/pce_req_if.sv
`default_nettype none

interface pce_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic signed [pce_pkg::DATA_W-1:0]    x_value;
   logic        [pce_pkg::ENTRY_W-1:0]   entry_index;
   logic signed [pce_pkg::DATA_W-1:0]    range_low;
   logic signed [pce_pkg::DATA_W-1:0]    range_high;
   logic signed [pce_pkg::DATA_W-1:0]    coef_zero;
   logic signed [pce_pkg::DATA_W-1:0]    coef_one;
   logic signed [pce_pkg::DATA_W-1:0]    coef_two;
   logic signed [pce_pkg::DATA_W-1:0]    coef_three;

   modport source (
      output valid, func, x_value, entry_index, range_low, range_high,
             coef_zero, coef_one, coef_two, coef_three,
      input  ready
   );

   modport sink (
      input  valid, func, x_value, entry_index, range_low, range_high,
             coef_zero, coef_one, coef_two, coef_three,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/pce_rsp_if.sv
`default_nettype none

interface pce_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pce_pkg::DATA_W-1:0]    poly_value;
   logic                                 no_match;
   logic        [pce_pkg::ENTRY_W-1:0]   segment_used;

   modport source (
      output valid, poly_value, no_match, segment_used,
      input  ready
   );

   modport sink (
      input  valid, poly_value, no_match, segment_used,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/piecewise_cubic_evaluator.sv
// Piecewise cubic evaluator: a load item (func 0) writes one segment entry if
// its index lies in the table and returns nothing; an evaluate item (func 1)
// returns one Q16.16 result. The search walks the segment table from the last
// hit, each segment visited taking a registered table read, then a bounds
// compare, and then evaluates the cubic by Horner's rule on one shared 32x32
// multiplier and adder, each step a multiply state, then an add state. No new
// item is taken from the moment an evaluate item is taken until its result is
// placed in the output register. If segments_in_use was lowered to or below
// the last hit, the start index is first reduced by repeated subtraction of
// the count. The result sits in an output register, so the next item is taken
// while it waits.

`default_nettype none

module piecewise_cubic_evaluator #(
   parameter int MAX_SEGMENTS = pce_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pce_req_if.sink                                req,
   pce_rsp_if.source                              rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pce_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [pce_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [pce_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int LIM = (MAX_SEGMENTS < pce_pkg::SEG_LIMIT) ? MAX_SEGMENTS
                                                            : pce_pkg::SEG_LIMIT;
   localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;
   localparam int CNT_W = $clog2(LIM + 1);
   localparam int DW = pce_pkg::DATA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_FETCH,
      S_TEST,
      S_MUL,
      S_ADD,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [pce_pkg::SEG_CNT_W-1:0] seg_ff, seg_in;
   logic [IDX_W-1:0]            last_hit_ff, last_hit_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [1:0]                  step_ff, step_in;
   logic signed [DW-1:0]        x_ff, x_in;
   logic signed [DW-1:0]        acc_ff, acc_in;
   logic signed [2*DW-1:0]      prod_ff, prod_in;
   logic                        no_match_ff, no_match_in;
   logic [IDX_W-1:0]            used_ff, used_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]        rsp_value_ff, rsp_value_in;
   logic                        rsp_no_match_ff, rsp_no_match_in;
   logic [pce_pkg::ENTRY_W-1:0] rsp_used_ff, rsp_used_in;

   logic [2*DW-1:0]             bounds_mem [LIM];
   logic [4*DW-1:0]             coef_mem [LIM];
   logic [2*DW-1:0]             bounds_rd_ff;
   logic [4*DW-1:0]             coef_rd_ff;

   logic                        req_take;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [CNT_W-1:0]            n_eff;
   logic [IDX_W-1:0]            n_last;
   logic signed [DW-1:0]        seg_lo, seg_hi;
   logic signed [DW-1:0]        coef_sel;
   logic signed [2*DW-1:0]      step_sum;
   logic                        csr_we;

   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid && req.ready;

   assign mem_we    = req_take && (req.func == pce_pkg::FUNC_LOAD)
                      && (32'(req.entry_index) < LIM);
   assign mem_waddr = req.entry_index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bounds_mem[mem_waddr] <= {req.range_high, req.range_low};
         coef_mem[mem_waddr]   <= {req.coef_three, req.coef_two, req.coef_one, req.coef_zero};
      end
      bounds_rd_ff <= bounds_mem[idx_ff];
      coef_rd_ff   <= coef_mem[idx_ff];
   end

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == pce_pkg::REG_SEGMENTS_IN_USE);

   always_comb begin
      if (csr_paddr[2] == pce_pkg::REG_SEGMENTS_IN_USE) begin
         csr_prdata = {{(pce_pkg::CSR_DATA_W-pce_pkg::SEG_CNT_W){1'b0}}, seg_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_comb begin
      if (seg_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(seg_ff) > LIM) begin
         n_eff = CNT_W'(LIM);
      end else begin
         n_eff = CNT_W'(seg_ff);
      end
   end

   assign n_last   = IDX_W'(n_ff - CNT_W'(1));
   assign seg_lo   = $signed(bounds_rd_ff[DW-1:0]);
   assign seg_hi   = $signed(bounds_rd_ff[2*DW-1:DW]);
   assign coef_sel = $signed(coef_rd_ff[step_ff*DW +: DW]);
   assign step_sum = (prod_ff >>> 16) + 64'(coef_sel);

   always_comb begin
      state_in        = state_ff;
      seg_in          = seg_ff;
      last_hit_in     = last_hit_ff;
      idx_in          = idx_ff;
      n_in            = n_ff;
      k_in            = k_ff;
      step_in         = step_ff;
      x_in            = x_ff;
      acc_in          = acc_ff;
      prod_in         = prod_ff;
      no_match_in     = no_match_ff;
      used_in         = used_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_no_match_in = rsp_no_match_ff;
      rsp_used_in     = rsp_used_ff;

      if (csr_we) begin
         seg_in = csr_pwdata[pce_pkg::SEG_CNT_W-1:0];
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take && (req.func == pce_pkg::FUNC_EVAL)) begin
               x_in     = req.x_value;
               n_in     = n_eff;
               idx_in   = last_hit_ff;
               k_in     = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (CNT_W'(idx_ff) >= n_ff) begin
               idx_in = IDX_W'(CNT_W'(idx_ff) - n_ff);
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            if ((x_ff >= seg_lo) && (x_ff < seg_hi)) begin
               last_hit_in = idx_ff;
               used_in     = idx_ff;
               no_match_in = 1'b0;
               acc_in      = $signed(coef_rd_ff[4*DW-1:3*DW]);
               step_in     = 2'd2;
               state_in    = S_MUL;
            end else if (((x_ff >= seg_hi) && (idx_ff == n_last))
                         || ((x_ff < seg_lo) && (idx_ff == '0))) begin
               used_in     = idx_ff;
               no_match_in = 1'b0;
               acc_in      = $signed(coef_rd_ff[4*DW-1:3*DW]);
               step_in     = 2'd2;
               state_in    = S_MUL;
            end else if (k_ff == n_ff - CNT_W'(1)) begin
               used_in     = '0;
               no_match_in = 1'b1;
               acc_in      = '0;
               state_in    = S_DONE;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               idx_in   = (idx_ff == n_last) ? '0 : idx_ff + IDX_W'(1);
               state_in = S_FETCH;
            end
         end
         S_MUL: begin
            prod_in  = acc_ff * x_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            if (step_sum > 64'sh7FFF_FFFF) begin
               acc_in = 32'sh7FFF_FFFF;
            end else if (step_sum < -64'sh8000_0000) begin
               acc_in = 32'sh8000_0000;
            end else begin
               acc_in = step_sum[DW-1:0];
            end
            if (step_ff == 2'd0) begin
               state_in = S_DONE;
            end else begin
               step_in  = step_ff - 2'd1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = acc_ff;
               rsp_no_match_in = no_match_ff;
               rsp_used_in     = pce_pkg::ENTRY_W'(used_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_ff       <= pce_pkg::SEG_CNT_W'(1);
         last_hit_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         last_hit_ff  <= last_hit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      k_ff            <= k_in;
      step_ff         <= step_in;
      x_ff            <= x_in;
      acc_ff          <= acc_in;
      prod_ff         <= prod_in;
      no_match_ff     <= no_match_in;
      used_ff         <= used_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_no_match_ff <= rsp_no_match_in;
      rsp_used_ff     <= rsp_used_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.poly_value   = rsp_value_ff;
   assign rsp.no_match     = rsp_no_match_ff;
   assign rsp.segment_used = rsp_used_ff;

   a_test_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST) |-> ((CNT_W'(idx_ff) < n_ff) && (k_ff < n_ff)))
      else $error("search visits an entry beyond the segment count");

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.no_match) |-> (32'(rsp.segment_used) < LIM))
      else $error("result names a segment outside the table");

   a_gap_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && no_match_ff) |-> (acc_ff == '0 && used_ff == '0))
      else $error("gap result carries a nonzero value or segment");

endmodule

`default_nettype wire
